>>> rtl/srsm_pkg.sv
// ============================================================================
// Simple regex search matcher: shared package
// Types, codes and defaults shared by the matcher's cells, closure unit and
// top level.
// ============================================================================
package srsm_pkg;

    // Default table depth; one cell per atom.
    localparam int MAX_ATOMS_DEF = 32;

    // Width of the pattern length register.
    localparam int PLEN_W = 6;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_BYTE = 2'd1,
        OP_END  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY     = 2'd1,
        KIND_START   = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        QUANT_ONE  = 2'd0,
        QUANT_OPT  = 2'd1,
        QUANT_STAR = 2'd2,
        QUANT_PLUS = 2'd3
    } t_quant;

    typedef struct packed {
        t_kind       kind;
        t_quant      quant;
        logic [7:0]  literal;
    } t_atom;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic        step;
        logic        clear;
        logic        at_start;
        logic        at_end;
        logic [7:0]  text_byte;
    } t_step;

endpackage

>>> rtl/srsm_if.sv
// ============================================================================
// Simple regex search matcher: channel interfaces
// Valid/ready channels for input items and for match results.
// ============================================================================
interface srsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  atom_index;
    logic [1:0]  atom_kind;
    logic [1:0]  atom_quantifier;
    logic [7:0]  atom_literal;
    logic [7:0]  text_byte;

    modport source (
        output valid, operation, atom_index, atom_kind, atom_quantifier,
               atom_literal, text_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, atom_index, atom_kind, atom_quantifier,
               atom_literal, text_byte,
        output ready
    );
endinterface

interface srsm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink (input valid, matched, output ready);
endinterface

>>> rtl/srsm_cell.sv
// ============================================================================
// Simple regex search matcher: atom cell
// Holds one pattern atom and its position bit, and moves that bit on to the
// next cell when the atom consumes the current text byte.
// ============================================================================
module srsm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srsm_pkg::t_step   i_ctrl,
    input  logic              i_load_en,
    input  srsm_pkg::t_atom   i_atom,
    input  logic              i_live,
    input  logic              i_used,
    input  logic              i_fwd,
    input  logic              i_closed,
    output logic              o_pos,
    output logic              o_pass,
    output logic              o_fwd
);

    srsm_pkg::t_atom r_atom;
    logic            r_pos;
    logic            n_pos;
    logic            w_hit;
    logic            w_self;

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_atom <= i_atom;
        end
    end

    // Zero-width move from this position to the next one.
    always_comb begin
        case (r_atom.kind)
            srsm_pkg::KIND_START: o_pass = i_used & i_ctrl.at_start;
            srsm_pkg::KIND_END:   o_pass = i_used & i_ctrl.at_end;
            default: o_pass = i_used & ((r_atom.quant == srsm_pkg::QUANT_OPT) ||
                                        (r_atom.quant == srsm_pkg::QUANT_STAR));
        endcase
    end

    always_comb begin
        case (r_atom.kind)
            srsm_pkg::KIND_ANY:     w_hit = 1'b1;
            srsm_pkg::KIND_LITERAL: w_hit = (r_atom.literal == i_ctrl.text_byte);
            default:                w_hit = 1'b0;
        endcase
    end

    assign o_fwd  = i_used & i_closed & w_hit;
    assign w_self = o_fwd & ((r_atom.quant == srsm_pkg::QUANT_STAR) ||
                             (r_atom.quant == srsm_pkg::QUANT_PLUS));
    assign o_pos  = r_pos & i_live;

    always_comb begin
        n_pos = r_pos;
        if (i_ctrl.step) begin
            n_pos = i_fwd | w_self;
        end else if (i_ctrl.clear) begin
            n_pos = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 1'b0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

>>> rtl/srsm_closure.sv
// ============================================================================
// Simple regex search matcher: zero-width closure
// Spreads every active position forward across runs of zero-width moves
// with one carry-propagate add, and picks out the accept position.
// ============================================================================
module srsm_closure #(
    parameter int MAX_ATOMS = srsm_pkg::MAX_ATOMS_DEF,
    parameter int LEN_W     = $clog2(MAX_ATOMS + 1)
) (
    input  logic [MAX_ATOMS:0]  i_pos,
    input  logic [MAX_ATOMS:0]  i_pass,
    input  logic [LEN_W-1:0]    i_len,
    output logic [MAX_ATOMS:0]  o_closed,
    output logic                o_accept
);

    logic [MAX_ATOMS:0]  w_seed;
    logic [MAX_ATOMS:0]  w_sum;

    // Position zero is injected before every byte so a match may start anywhere.
    assign w_seed = i_pos | {{MAX_ATOMS{1'b0}}, 1'b1};

    // A carry entering a run of pass bits ripples to the first position past it;
    // the XOR recovers every bit the carry travelled through. The highest
    // position never passes, so no carry leaves the top of the sum.
    assign w_sum    = (w_seed & i_pass) + i_pass;
    assign o_closed = w_seed | (w_sum ^ i_pass);
    assign o_accept = o_closed[i_len];

endmodule

>>> rtl/simple_regex_search_matcher.sv
// ============================================================================
// Simple regex search matcher: top level
// Searches streamed text for any substring that matches a loaded pattern.
// ============================================================================
// Usage. One input channel carries three kinds of transaction: a load that
// writes one atom (kind, quantifier, literal) into the table, a text byte,
// and an end-of-text marker. The pattern length register is written through
// i_cfg_we / i_cfg_data while the block is idle; values above MAX_ATOMS are
// clamped. Load the atoms, set the length, then stream the text followed by
// an end-of-text transaction, which yields exactly one result transaction
// carrying the matched flag. Loads and text bytes produce no result.
//
// One cell per atom updates its position bit per byte, and the zero-width
// closure across the row is one carry-propagate add, so an item may be
// accepted on every clock while input ready is high. The result is
// registered into a two-entry output queue when its end-of-text transaction
// is accepted. Input ready drops only when both queue entries are full,
// i.e. the receiver has stalled for two results in a row.
//
// Synchronous reset clears the position set, the match flag, the output
// queue and the length register, and arms the start-of-text condition. The
// atom table has no reset and must be loaded before use.
// ============================================================================
module simple_regex_search_matcher #(
    parameter int MAX_ATOMS = srsm_pkg::MAX_ATOMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    srsm_in_if.sink                      i_item,
    srsm_out_if.source                   o_result,
    input  logic                         i_cfg_we,
    input  logic [srsm_pkg::PLEN_W-1:0]  i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_ATOMS + 1);

    srsm_pkg::t_op                 w_op;
    srsm_pkg::t_atom               w_atom;
    srsm_pkg::t_step               w_ctrl;
    logic                          w_in_acc;
    logic                          w_load;
    logic                          w_byte;
    logic                          w_end;
    logic [LEN_W-1:0]              w_len;
    logic [MAX_ATOMS:0]            w_pos;
    logic [MAX_ATOMS:0]            w_pass;
    logic [MAX_ATOMS:0]            w_closed;
    logic [MAX_ATOMS:0]            w_fwd;
    logic                          w_accept;
    logic                          w_result;
    logic                          w_pop;

    logic [srsm_pkg::PLEN_W-1:0]   r_plen;
    logic                          r_at_start;
    logic                          n_at_start;
    logic                          r_found;
    logic                          n_found;
    logic                          r_acc;
    logic                          n_acc;
    logic                          r_v0;
    logic                          n_v0;
    logic                          r_v1;
    logic                          n_v1;
    logic                          r_d0;
    logic                          n_d0;
    logic                          r_d1;
    logic                          n_d1;

    // ---------------------------------------------------------------------
    // Input decode. Operation code three is accepted and ignored.
    // ---------------------------------------------------------------------
    assign w_op     = srsm_pkg::t_op'(i_item.operation);
    assign w_in_acc = i_item.valid & i_item.ready;

    always_comb begin
        w_load = 1'b0;
        w_byte = 1'b0;
        w_end  = 1'b0;
        unique case (w_op)
            srsm_pkg::OP_LOAD: w_load = w_in_acc;
            srsm_pkg::OP_BYTE: w_byte = w_in_acc;
            srsm_pkg::OP_END:  w_end  = w_in_acc;
            default: ;
        endcase
    end

    assign w_atom.kind    = srsm_pkg::t_kind'(i_item.atom_kind);
    assign w_atom.quant   = srsm_pkg::t_quant'(i_item.atom_quantifier);
    assign w_atom.literal = i_item.atom_literal;

    // The end anchor only passes when the end-of-text transaction is evaluated.
    assign w_ctrl.step      = w_byte;
    assign w_ctrl.clear     = w_end;
    assign w_ctrl.at_start  = r_at_start;
    assign w_ctrl.at_end    = (w_op == srsm_pkg::OP_END);
    assign w_ctrl.text_byte = i_item.text_byte;

    // ---------------------------------------------------------------------
    // Pattern length register, clamped to the number of cells.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
        end else if (i_cfg_we) begin
            r_plen <= i_cfg_data;
        end
    end

    assign w_len = (r_plen > srsm_pkg::PLEN_W'(MAX_ATOMS)) ? LEN_W'(MAX_ATOMS)
                                                          : LEN_W'(r_plen);

    // ---------------------------------------------------------------------
    // Row of atom cells. Each hands its consume bit to the cell on its right,
    // which becomes that cell's position bit for the next byte.
    // ---------------------------------------------------------------------
    assign w_fwd[0] = 1'b0;

    for (genvar g = 0; g < MAX_ATOMS; g++) begin : g_cell
        srsm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_load_en (w_load && (32'(i_item.atom_index) == g)),
            .i_atom    (w_atom),
            .i_live    (LEN_W'(g) <= w_len),
            .i_used    (LEN_W'(g) < w_len),
            .i_fwd     (w_fwd[g]),
            .i_closed  (w_closed[g]),
            .o_pos     (w_pos[g]),
            .o_pass    (w_pass[g]),
            .o_fwd     (w_fwd[g+1])
        );
    end

    // The position past the last cell exists only when the pattern fills the row.
    assign w_pos[MAX_ATOMS]  = r_acc & (w_len == LEN_W'(MAX_ATOMS));
    assign w_pass[MAX_ATOMS] = 1'b0;

    always_comb begin
        n_acc = r_acc;
        if (w_byte) begin
            n_acc = w_fwd[MAX_ATOMS];
        end else if (w_end) begin
            n_acc = 1'b0;
        end
    end

    srsm_closure #(
        .MAX_ATOMS (MAX_ATOMS),
        .LEN_W     (LEN_W)
    ) u_closure (
        .i_pos    (w_pos),
        .i_pass   (w_pass),
        .i_len    (w_len),
        .o_closed (w_closed),
        .o_accept (w_accept)
    );

    // ---------------------------------------------------------------------
    // Per-text state: start-of-text flag and the sticky match flag.
    // ---------------------------------------------------------------------
    always_comb begin
        n_at_start = r_at_start;
        n_found    = r_found;
        if (w_byte) begin
            n_at_start = 1'b0;
            n_found    = r_found | w_accept;
        end else if (w_end) begin
            n_at_start = 1'b1;
            n_found    = 1'b0;
        end
    end

    assign w_result = r_found | w_accept;

    // ---------------------------------------------------------------------
    // Two-entry output queue; entry zero drives the result channel.
    // ---------------------------------------------------------------------
    assign w_pop = r_v0 & o_result.ready;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (w_pop) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (w_end) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = w_result;
            end else begin
                n_v1 = 1'b1;
                n_d1 = w_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_found    <= 1'b0;
            r_acc      <= 1'b0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
        end else begin
            r_at_start <= n_at_start;
            r_found    <= n_found;
            r_acc      <= n_acc;
            r_v0       <= n_v0;
            r_v1       <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign i_item.ready     = ~r_v1;
    assign o_result.valid   = r_v0;
    assign o_result.matched = r_d0;

endmodule

>>> rtl/srsm_checker.sv
// ============================================================================
// Simple regex search matcher: port checker
// Concurrent assertions on the matcher's channels, bound to the top level.
// ============================================================================
module srsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_operation,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_matched
);

    logic w_end_acc;

    assign w_end_acc = i_in_valid && i_in_ready &&
                       (srsm_pkg::t_op'(i_in_operation) == srsm_pkg::OP_END);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A result only appears after an end-of-text transaction.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_end_acc))
        else $error("result without end of text");

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_matched)))
        else $error("stalled result changed");

    // Input back-pressure only while a result waits.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty result queue");

    // Ready falls only when an end of text arrives while the receiver stalls.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready && w_end_acc))
        else $error("input ready fell without a stalled result");

endmodule

bind simple_regex_search_matcher srsm_checker u_srsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_in_operation (i_item.operation),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_matched  (o_result.matched)
);
